@@ design/timed_alarm_rotation_queue_defines.svh @@
// Assertion macros for the timed alarm rotation queue.
`ifndef TIMED_ALARM_ROTATION_QUEUE_DEFINES_SVH
`define TIMED_ALARM_ROTATION_QUEUE_DEFINES_SVH
`ifndef SYNTHESIS
`define TARQ_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define TARQ_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define TARQ_ASSERT(label, clk, rst_n, prop)
`define TARQ_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

@@ design/tarq_pkg.sv @@
// Shared types and constants for the timed alarm rotation queue.
package tarq_pkg;
  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_SCHED  = 2'd1;
  localparam logic [1:0] CMD_REPLAY = 2'd2;
  localparam logic [1:0] CMD_QUERY  = 2'd3;
  localparam logic [7:0] TIMER_RESET = 8'd150;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] alarm_number;
    logic [7:0] profile_id;
    logic [7:0] visual_bits_one;
    logic [7:0] visual_bits_two;
    logic [7:0] duration;
    logic [7:0] replay_delay;
  } tarq_in_t;

  typedef struct packed {
    logic       accepted;
    logic [3:0] match_count;
    logic [7:0] visual_or_one;
    logic [7:0] visual_or_two;
    logic       shown_matches;
    logic [7:0] shown_number;
    logic [3:0] active_count;
    logic [3:0] hold_count;
  } tarq_out_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SCAN, ST_ACT, ST_HCHK, ST_HPUSH, ST_ROT, ST_DEC, ST_DONE, ST_OUT
  } tarq_state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture item, clear scan state
    logic scan_a;    // active scan step
    logic scan_h;    // hold scan step
    logic act_step;  // process one entry of the operation
    logic hchk;      // check one hold entry for duplicate
    logic hpush;     // push pending alarm to hold table
    logic rotate;    // timer and rotation
    logic dec;       // shown time decrement
    logic finish;    // form result
    logic release_r; // result taken
  } tarq_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic a_done;
    logic h_done;
    logic expire_hold; // current active entry expires and needs hold push
    logic sched;
    logic replay;
    logic add;
    logic query;
    logic empty_tick;
  } tarq_stat_t;
endpackage

@@ design/tarq_if.sv @@
// Valid/ready channel interface.
interface tarq_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ design/tarq_ctrl.sv @@
// Controller state machine for the timed alarm rotation queue.
module tarq_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  tarq_pkg::tarq_stat_t  stat,
  output tarq_pkg::tarq_cmd_t   cmd
);
  import tarq_pkg::*;
  `include "timed_alarm_rotation_queue_defines.svh"

  tarq_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_SCAN;
      ST_SCAN: begin
        if (stat.a_done && stat.h_done) begin
          if (stat.sched && stat.empty_tick) state_nxt = ST_DONE;
          else state_nxt = ST_ACT;
        end
      end
      ST_ACT: begin
        if (stat.expire_hold) state_nxt = ST_HCHK;
        else if (stat.a_done && stat.h_done) state_nxt = stat.sched ? ST_ROT : ST_DONE;
      end
      ST_HCHK: if (stat.h_done) state_nxt = ST_HPUSH;
      ST_HPUSH: state_nxt = ST_ACT;
      ST_ROT: state_nxt = ST_DEC;
      ST_DEC: state_nxt = ST_DONE;
      ST_DONE: state_nxt = ST_OUT;
      ST_OUT: if (out_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_SCAN: begin
        cmd.scan_a = 1'b1;
        cmd.scan_h = 1'b1;
      end
      ST_ACT:   cmd.act_step = 1'b1;
      ST_HCHK:  cmd.hchk = 1'b1;
      ST_HPUSH: cmd.hpush = 1'b1;
      ST_ROT:   cmd.rotate = 1'b1;
      ST_DEC:   cmd.dec = 1'b1;
      ST_DONE:  cmd.finish = 1'b1;
      ST_OUT: begin
        out_valid = 1'b1;
        cmd.release_r = out_ready;
      end
      default: ;
    endcase
  end

  `TARQ_ASSERT(a_ready_idle, clk, rst_n, in_ready |-> !out_valid)
  `TARQ_ASSERT(a_out_after_done, clk, rst_n, $rose(out_valid) |-> $past(cmd.finish))
  `TARQ_ASSERT(a_load_leaves_idle, clk, rst_n, cmd.load |=> !in_ready)
endmodule

@@ design/tarq_dp.sv @@
// Datapath: alarm tables, scan pointers, timer and result register.
module tarq_dp #(
  parameter int QUEUE_DEPTH  = 8,
  parameter int ROTATE_TICKS = 100
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  tarq_pkg::tarq_in_t    in_item,
  input  tarq_pkg::tarq_cmd_t   cmd,
  output tarq_pkg::tarq_stat_t  stat,
  output tarq_pkg::tarq_out_t   result
);
  import tarq_pkg::*;
  `include "timed_alarm_rotation_queue_defines.svh"

  localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam logic [3:0] DEPTH4 = 4'(QUEUE_DEPTH);
  localparam logic [7:0] ROT8 = 8'(ROTATE_TICKS);

  logic [7:0] a_num_r [QUEUE_DEPTH];
  logic [7:0] a_prof_r [QUEUE_DEPTH];
  logic [7:0] a_vis1_r [QUEUE_DEPTH];
  logic [7:0] a_vis2_r [QUEUE_DEPTH];
  logic [7:0] a_time_r [QUEUE_DEPTH];
  logic [7:0] a_delay_r [QUEUE_DEPTH];
  logic [7:0] h_num_r [QUEUE_DEPTH];
  logic [7:0] h_prof_r [QUEUE_DEPTH];
  logic [7:0] h_delay_r [QUEUE_DEPTH];

  logic [3:0] a_cnt_r, h_cnt_r, shown_r;
  logic [7:0] timer_r;
  tarq_in_t   item_r;
  tarq_out_t  result_r;

  // scan/compaction state
  logic [3:0] ra_r, wa_r, rh_r, wh_r;
  logic       dup_r, hdup_r;
  logic [3:0] mcnt_r;
  logic [7:0] or1_r, or2_r, snum_r;
  logic       smatch_r, acc_r;

  logic [IW-1:0] ra_i, wa_i, rh_i, wh_i, sh_i, hc_i;
  assign ra_i = ra_r[IW-1:0];
  assign wa_i = wa_r[IW-1:0];
  assign rh_i = rh_r[IW-1:0];
  assign wh_i = wh_r[IW-1:0];
  assign hc_i = h_cnt_r[IW-1:0];
  assign sh_i = 4'(shown_r - 4'd1) < DEPTH4 ? IW'(shown_r - 4'd1) : '0;

  logic a_more, h_more, is_sched, is_add, is_replay, is_query;
  assign a_more = ra_r < a_cnt_r;
  assign h_more = rh_r < h_cnt_r;
  assign is_add = item_r.command == CMD_ADD;
  assign is_sched = item_r.command == CMD_SCHED;
  assign is_replay = item_r.command == CMD_REPLAY;
  assign is_query = item_r.command == CMD_QUERY;

  logic expire;
  assign expire = is_sched && a_more && a_time_r[ra_i] == 8'd0;

  always_comb begin
    stat = '0;
    stat.a_done = !a_more;
    stat.h_done = !h_more;
    stat.expire_hold = cmd.act_step && expire && a_delay_r[ra_i] != 8'd0;
    stat.sched = is_sched;
    stat.replay = is_replay;
    stat.add = is_add;
    stat.query = is_query;
    stat.empty_tick = a_cnt_r == 4'd0;
  end

  logic [7:0] hdec;
  assign hdec = h_delay_r[rh_i] - 8'd1;
  logic [7:0] tnext;
  assign tnext = timer_r + 8'd1;
  logic [4:0] snext;
  assign snext = {1'b0, shown_r} + 5'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_cnt_r <= '0;
      h_cnt_r <= '0;
      shown_r <= '0;
      timer_r <= TIMER_RESET;
    end else begin
      if (cmd.load) begin
        item_r <= in_item;
        ra_r <= '0; wa_r <= '0; rh_r <= '0; wh_r <= '0;
        dup_r <= 1'b0; mcnt_r <= '0; or1_r <= '0; or2_r <= '0;
        snum_r <= '0; smatch_r <= 1'b0; acc_r <= 1'b0;
      end
      // duplicate scan and append for add; set up pointers for the operation after it
      if (cmd.scan_a) begin
        if (a_more) begin
          if (a_num_r[ra_i] == item_r.alarm_number && a_prof_r[ra_i] == item_r.profile_id)
            dup_r <= 1'b1;
          ra_r <= ra_r + 4'd1;
        end
        if (h_more) begin
          if (h_num_r[rh_i] == item_r.alarm_number && h_prof_r[rh_i] == item_r.profile_id)
            dup_r <= 1'b1;
          rh_r <= rh_r + 4'd1;
        end
        if (!a_more && !h_more) begin
          if (is_add) begin
            // nothing to walk: park both pointers at the final counts
            if (a_cnt_r < DEPTH4 && !dup_r) begin
              a_num_r[a_cnt_r[IW-1:0]] <= item_r.alarm_number;
              a_prof_r[a_cnt_r[IW-1:0]] <= item_r.profile_id;
              a_vis1_r[a_cnt_r[IW-1:0]] <= item_r.visual_bits_one;
              a_vis2_r[a_cnt_r[IW-1:0]] <= item_r.visual_bits_two;
              a_time_r[a_cnt_r[IW-1:0]] <= item_r.duration;
              a_delay_r[a_cnt_r[IW-1:0]] <= item_r.replay_delay;
              a_cnt_r <= a_cnt_r + 4'd1;
              ra_r <= a_cnt_r + 4'd1;
              acc_r <= 1'b1;
            end else begin
              ra_r <= a_cnt_r;
            end
            rh_r <= h_cnt_r;
          end else if (is_replay) begin
            ra_r <= a_cnt_r; // active table untouched
            rh_r <= '0;
          end else begin
            ra_r <= '0;
            rh_r <= h_cnt_r; // tick and query walk active only
          end
        end
      end
      if (cmd.act_step) begin
        if (is_replay) begin
          if (h_more) begin
            if (hdec != 8'd0) begin
              h_num_r[wh_i] <= h_num_r[rh_i];
              h_prof_r[wh_i] <= h_prof_r[rh_i];
              h_delay_r[wh_i] <= hdec;
              wh_r <= wh_r + 4'd1;
            end
            rh_r <= rh_r + 4'd1;
          end else begin
            h_cnt_r <= wh_r;
          end
        end else if (is_query) begin
          if (a_more) begin
            if (a_prof_r[ra_i] == item_r.profile_id) begin
              or1_r <= or1_r | a_vis1_r[ra_i];
              or2_r <= or2_r | a_vis2_r[ra_i];
              mcnt_r <= mcnt_r + 4'd1;
              if (ra_r + 4'd1 == shown_r) begin
                smatch_r <= 1'b1;
                snum_r <= a_num_r[ra_i];
              end
            end
            ra_r <= ra_r + 4'd1;
          end
        end else if (is_sched) begin
          if (a_more) begin
            if (expire) begin
              // held entries go through the hold check first
              if (a_delay_r[ra_i] == 8'd0) ra_r <= ra_r + 4'd1;
              else begin
                rh_r <= '0;
                hdup_r <= 1'b0;
              end
            end else begin
              a_num_r[wa_i] <= a_num_r[ra_i];
              a_prof_r[wa_i] <= a_prof_r[ra_i];
              a_vis1_r[wa_i] <= a_vis1_r[ra_i];
              a_vis2_r[wa_i] <= a_vis2_r[ra_i];
              a_time_r[wa_i] <= a_time_r[ra_i];
              a_delay_r[wa_i] <= a_delay_r[ra_i];
              wa_r <= wa_r + 4'd1;
              ra_r <= ra_r + 4'd1;
            end
          end
        end
      end
      if (cmd.hchk && h_more) begin
        if (h_num_r[rh_i] == a_num_r[ra_i] && h_prof_r[rh_i] == a_prof_r[ra_i])
          hdup_r <= 1'b1;
        rh_r <= rh_r + 4'd1;
      end
      if (cmd.hpush) begin
        // park the hold pointer at the count: scan idle
        if (h_cnt_r < DEPTH4 && !hdup_r) begin
          h_num_r[hc_i] <= a_num_r[ra_i];
          h_prof_r[hc_i] <= a_prof_r[ra_i];
          h_delay_r[hc_i] <= a_delay_r[ra_i];
          h_cnt_r <= h_cnt_r + 4'd1;
          rh_r <= h_cnt_r + 4'd1;
        end else begin
          rh_r <= h_cnt_r;
        end
        ra_r <= ra_r + 4'd1;
      end
      if (cmd.rotate) begin
        a_cnt_r <= wa_r;
        if (shown_r != 4'd0) begin
          timer_r <= tnext;
          // flag the decrement and the rotation in scratch bits
          smatch_r <= !tnext[0] && shown_r <= wa_r;
          acc_r <= tnext >= ROT8;
        end else begin
          smatch_r <= 1'b0;
          acc_r <= 1'b1;
        end
      end
      if (cmd.dec) begin
        if (smatch_r) a_time_r[sh_i] <= a_time_r[sh_i] - 8'd1;
        if (acc_r) begin
          timer_r <= '0;
          if (a_cnt_r == 4'd0) shown_r <= '0;
          else if (snext > {1'b0, a_cnt_r}) shown_r <= 4'd1;
          else shown_r <= snext[3:0];
        end
        smatch_r <= 1'b0;
        acc_r <= 1'b0;
      end
      if (cmd.finish) begin
        result_r.accepted <= is_add & acc_r;
        result_r.match_count <= is_query ? mcnt_r : 4'd0;
        result_r.visual_or_one <= is_query ? or1_r : 8'd0;
        result_r.visual_or_two <= is_query ? or2_r : 8'd0;
        result_r.shown_matches <= is_query & smatch_r;
        result_r.shown_number <= is_query ? snum_r : 8'd0;
        result_r.active_count <= a_cnt_r;
        result_r.hold_count <= h_cnt_r;
      end
    end
  end

  assign result = result_r;

  `TARQ_ASSERT(a_act_bound, clk, rst_n, a_cnt_r <= DEPTH4)
  `TARQ_ASSERT(a_hold_bound, clk, rst_n, h_cnt_r <= DEPTH4)
  `TARQ_ASSERT(a_shown_bound, clk, rst_n, cmd.finish |-> shown_r <= DEPTH4)
endmodule

@@ design/timed_alarm_rotation_queue.sv @@
// Top level of the timed alarm rotation queue.
//  channel | dir | payload
//  in      | in  | command, alarm_number, profile_id, visuals, duration, replay_delay
//  out     | out | accepted, match counts, visual ORs, shown alarm, table counts
// One item at a time: the block takes it, runs a duplicate scan over both
// tables, then walks entries (active for tick and query, hold for replay, none
// for add); each expiring alarm with a replay delay adds a hold check and push,
// a tick adds the timer and rotation steps (an empty tick skips walk and timer),
// and a final step forms the result.
// Reset clears counts and shown position and loads the timer with 150; a stalled result holds the block.
module timed_alarm_rotation_queue #(
  parameter int QUEUE_DEPTH  = 8,
  parameter int ROTATE_TICKS = 100
) (
  input logic clk,
  input logic rst_n,
  tarq_if.sink   in_ch,
  tarq_if.source out_ch
);
  import tarq_pkg::*;

  tarq_cmd_t  cmd;
  tarq_stat_t stat;
  tarq_out_t  result;

  tarq_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .stat(stat), .cmd(cmd)
  );

  tarq_dp #(.QUEUE_DEPTH(QUEUE_DEPTH), .ROTATE_TICKS(ROTATE_TICKS)) u_dp (
    .clk(clk), .rst_n(rst_n),
    .in_item(in_ch.payload), .cmd(cmd), .stat(stat), .result(result)
  );

  // hold the finished item on the output
  assign out_ch.payload = result;
endmodule
